FILE: src/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

FILE: src/spwm_pkg.sv
// Shared types and constants of the servo/PWM command encoder.
// No dependencies; used by the modules, the checker and the testbench.
package spwm_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PULSE_W  = 15;

  localparam int ANGLE_LIMIT = 554;
  localparam int ANGLE_MAX   = 180;
  localparam int FRAME_US    = 20000;
  localparam int TICKS       = 4096;
  localparam int DUTY_MAX    = 4095;
  localparam int DUTY_BITS   = 12;
  localparam int LED_BASE    = 6;
  localparam int ALL_LED_REG = 250;
  localparam int WRES_RESET  = 8;

  // ticks = pulse * 4096 / 20000 = (pulse << TICK_SHIFT) / TICK_DIV
  localparam int TICK_SHIFT = 9;
  localparam int TICK_DIV   = (FRAME_US * (1 << TICK_SHIFT)) / TICKS;

  // Reciprocal estimates; each leaves a quotient that is low by at most one.
  // The angle product of a full 15-bit span needs 23 bits of magnitude.
  localparam int ANG_RSH     = 24;
  localparam int RECIP_ANG   = (1 << ANG_RSH) / ANGLE_MAX;
  localparam int TICK_RSH    = PULSE_W + TICK_SHIFT;
  localparam int RECIP_TICK  = (1 << TICK_RSH) / TICK_DIV;

  typedef enum logic [1:0] {
    OP_ATTACH = 2'd0,
    OP_SERVO  = 2'd1,
    OP_DUTY   = 2'd2
  } op_e;

  typedef struct packed {
    logic [PULSE_W-1:0] lo;
    logic [PULSE_W-1:0] hi;
  } limit_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic [CH_AW-1:0] addr;
    limit_t           wdata;
  } tbl_req_t;

endpackage

FILE: src/spwm_if.sv
// Handshake channels of the servo/PWM command encoder: command, result, config.
// No dependencies.
interface spwm_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [3:0]         channel;
  logic               all_channels;
  logic signed [15:0] servo_value;
  logic [31:0]        duty_value;
  logic [14:0]        pulse_min;
  logic [14:0]        pulse_max;

  modport source (output valid, opcode, channel, all_channels, servo_value,
                  duty_value, pulse_min, pulse_max, input ready);
  modport sink (input valid, opcode, channel, all_channels, servo_value,
                duty_value, pulse_min, pulse_max, output ready);
endinterface

interface spwm_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_address;
  logic [12:0] on_count;
  logic [12:0] off_count;

  modport source (output valid, reg_address, on_count, off_count, input ready);
  modport sink (input valid, reg_address, on_count, off_count, output ready);
endinterface

interface spwm_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] write_resolution;

  modport source (output valid, write_resolution, input ready);
  modport sink (input valid, write_resolution, output ready);
endinterface

FILE: src/servo_pwm_command_encoder_core.sv
// Servo/PWM command encoder. A servo write passes the LOOKUP, DIVA, DIVB, PULSE, TICKA,
// TICKB and ENCODE states before its result is valid, a duty write ENCODE alone; an attach
// gives none. One command at a time: a new one is taken only in IDLE, and ENCODE waits while
// the output word is unread; the servo path is the table read plus the two reciprocal divides.
// Reset (async, active low) marks every limit entry unwritten so it reads as zero,
// sets write_resolution to 8 and empties the output register; no clearing pass.
module servo_pwm_command_encoder_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  spwm_cmd_if.sink          cmd_i,
  spwm_cfg_if.sink          cfg_i,
  spwm_res_if.source        res_o
);

  localparam int CH_AW   = spwm_pkg::CH_AW;
  localparam int PW      = spwm_pkg::PULSE_W;
  localparam int TA_W    = PW + spwm_pkg::TICK_SHIFT;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_DIVA   = 3'd2;
  localparam logic [2:0] ST_DIVB   = 3'd3;
  localparam logic [2:0] ST_PULSE  = 3'd4;
  localparam logic [2:0] ST_TICKA  = 3'd5;
  localparam logic [2:0] ST_TICKB  = 3'd6;
  localparam logic [2:0] ST_ENCODE = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [5:0]  wres_q;

  logic        cmd_fire;
  logic        ch_ok;
  logic        slot_free;

  spwm_pkg::tbl_req_t tbl_req;
  spwm_pkg::limit_t   tbl_rdata;

  // Working registers of the servo path
  logic signed [15:0] sv_q;
  logic               angle_q;
  logic [PW-1:0]      lo_q, hi_q;
  logic signed [23:0] prod_q;
  logic               neg_q;
  logic [22:0]        mag_q;
  logic [PW-1:0]      qe_q;
  logic [PW-1:0]      quot_q;
  logic [PW-1:0]      pulse_q;
  logic [12:0]        tq_q;
  logic [15:0]        val_q;
  logic [7:0]         addr_q;

  // Output register
  logic               out_valid_q;
  logic [7:0]         out_addr_q;
  logic [12:0]        out_on_q, out_off_q;

  // Combinational datapath signals
  logic [31:0]        scaled;
  logic [5:0]         shift_dn, shift_up;
  logic [7:0]         ang;
  logic signed [15:0] diff;
  logic signed [24:0] prod_full;
  logic [23:0]        mag_full;
  logic [38:0]        rp_ang;
  logic [22:0]        corr_ang;
  logic [22:0]        rem_ang;
  logic signed [17:0] quot18, v18, lo18, hi18;
  logic [PW-1:0]      pulse_c;
  logic [TA_W-1:0]    tick_num;
  logic [36:0]        rp_tick;
  logic [25:0]        corr_tick;
  logic [TA_W-1:0]    rem_tick;
  logic [12:0]        ticks;
  logic [11:0]        sat12;

  // ---------------------------------------------------------------------------
  // Handshakes. Configuration is always taken; commands only while idle.
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign ch_ok       = int'(cmd_i.channel) < spwm_pkg::CHANNELS;
  assign slot_free   = !out_valid_q || res_o.ready;

  // ---------------------------------------------------------------------------
  // Limit table: attach writes at its transfer, a servo write reads at its
  // transfer. One command is in flight at a time, so a read never meets a
  // write to the same entry and no forwarding is needed.
  // ---------------------------------------------------------------------------
  always_comb begin
    tbl_req          = '0;
    tbl_req.addr     = CH_AW'(cmd_i.channel);
    tbl_req.wdata.lo = cmd_i.pulse_min;
    tbl_req.wdata.hi = cmd_i.pulse_max;
    tbl_req.wr_en    = cmd_fire && ch_ok && (cmd_i.opcode == spwm_pkg::OP_ATTACH);
    tbl_req.rd_en    = cmd_fire && ch_ok && (cmd_i.opcode == spwm_pkg::OP_SERVO);
  end

  spwm_limit_table u_limit_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // ---------------------------------------------------------------------------
  // Duty rescale from write_resolution bits to 12 bits. A wider source
  // shifts right (all gone at 32 or more), a narrower one shifts left and
  // wraps within 32 bits, equal width saturates.
  // ---------------------------------------------------------------------------
  assign shift_dn = wres_q - 6'(spwm_pkg::DUTY_BITS);
  assign shift_up = 6'(spwm_pkg::DUTY_BITS) - wres_q;

  always_comb begin
    if (wres_q == 6'(spwm_pkg::DUTY_BITS)) begin
      scaled = (cmd_i.duty_value >= 32'(spwm_pkg::TICKS)) ?
               32'(spwm_pkg::DUTY_MAX) : cmd_i.duty_value;
    end else if (wres_q > 6'(spwm_pkg::DUTY_BITS)) begin
      scaled = (shift_dn >= 6'd32) ? '0 : (cmd_i.duty_value >> shift_dn);
    end else begin
      scaled = cmd_i.duty_value << shift_up;
    end
  end

  // ---------------------------------------------------------------------------
  // Servo arithmetic, one step per sequencer state.
  // ---------------------------------------------------------------------------
  // LOOKUP: clamp the angle and scale it by the limit span
  always_comb begin
    if (sv_q < 16'sd0) begin
      ang = '0;
    end else if (sv_q > $signed(16'(spwm_pkg::ANGLE_MAX))) begin
      ang = 8'(spwm_pkg::ANGLE_MAX);
    end else begin
      ang = sv_q[7:0];
    end
  end

  assign diff      = $signed({1'b0, tbl_rdata.hi}) - $signed({1'b0, tbl_rdata.lo});
  assign prod_full = $signed({1'b0, ang}) * diff;

  // DIVA: magnitude times reciprocal of 180
  assign mag_full = prod_q[23] ? 24'(-prod_q) : 24'(prod_q);
  assign rp_ang   = 39'(mag_full[22:0]) * 39'(spwm_pkg::RECIP_ANG);

  // DIVB: fix up the estimate, which may be low by one
  assign corr_ang = 23'(qe_q) * 23'(spwm_pkg::ANGLE_MAX);
  assign rem_ang  = mag_q - corr_ang;

  // PULSE: restore the sign (truncation toward zero), add the minimum, clamp.
  // The minimum test wins, so crossed limits give the maximum at or above the minimum.
  assign quot18 = neg_q ? -$signed({3'b000, quot_q}) : $signed({3'b000, quot_q});
  assign lo18   = $signed({3'b000, lo_q});
  assign hi18   = $signed({3'b000, hi_q});
  assign v18    = angle_q ? (quot18 + lo18) : {{2{sv_q[15]}}, sv_q};

  always_comb begin
    if (v18 < lo18) begin
      pulse_c = lo_q;
    end else if (v18 > hi18) begin
      pulse_c = hi_q;
    end else begin
      pulse_c = v18[PW-1:0];
    end
  end

  // TICKA / TICKB: microseconds to frame ticks, same estimate-and-fix scheme
  assign tick_num  = {pulse_q, spwm_pkg::TICK_SHIFT'(0)};
  assign rp_tick   = 37'(tick_num) * 37'(spwm_pkg::RECIP_TICK);
  assign corr_tick = 26'(tq_q) * 26'(spwm_pkg::TICK_DIV);
  assign rem_tick  = tick_num - corr_tick[TA_W-1:0];
  assign ticks     = (rem_tick >= TA_W'(spwm_pkg::TICK_DIV)) ? (tq_q + 13'd1) : tq_q;

  // ENCODE: saturate at 4095, then pick full-on, full-off or a plain off tick
  assign sat12 = (val_q > 16'(spwm_pkg::DUTY_MAX)) ?
                 12'(spwm_pkg::DUTY_MAX) : val_q[11:0];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_fire) begin
          case (cmd_i.opcode)
            spwm_pkg::OP_SERVO: begin
              if (ch_ok) begin
                state_d = ST_LOOKUP;
              end
            end
            spwm_pkg::OP_DUTY: begin
              if (cmd_i.all_channels || ch_ok) begin
                state_d = ST_ENCODE;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOOKUP: state_d = ST_DIVA;
      ST_DIVA:   state_d = ST_DIVB;
      ST_DIVB:   state_d = ST_PULSE;
      ST_PULSE:  state_d = ST_TICKA;
      ST_TICKA:  state_d = ST_TICKB;
      ST_TICKB:  state_d = ST_ENCODE;
      ST_ENCODE: begin
        // hold until the output register can take the word
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wres_q      <= 6'(spwm_pkg::WRES_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        wres_q <= cfg_i.write_resolution;
      end
      if (state_q == ST_ENCODE && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: no reset, loaded by the step that owns them
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sv_q    <= cmd_i.servo_value;
        angle_q <= cmd_i.servo_value < $signed(16'(spwm_pkg::ANGLE_LIMIT));
        val_q   <= scaled[15:0];
        if (cmd_i.opcode == spwm_pkg::OP_DUTY && cmd_i.all_channels) begin
          addr_q <= 8'(spwm_pkg::ALL_LED_REG);
        end else begin
          addr_q <= 8'(spwm_pkg::LED_BASE) + 8'({cmd_i.channel, 2'b00});
        end
      end
      ST_LOOKUP: begin
        lo_q   <= tbl_rdata.lo;
        hi_q   <= tbl_rdata.hi;
        prod_q <= prod_full[23:0];
      end
      ST_DIVA: begin
        neg_q <= prod_q[23];
        mag_q <= mag_full[22:0];
        qe_q  <= rp_ang[spwm_pkg::ANG_RSH +: PW];
      end
      ST_DIVB: begin
        quot_q <= (rem_ang >= 23'(spwm_pkg::ANGLE_MAX)) ? (qe_q + 1'b1) : qe_q;
      end
      ST_PULSE: begin
        pulse_q <= pulse_c;
      end
      ST_TICKA: begin
        tq_q <= rp_tick[spwm_pkg::TICK_RSH +: 13];
      end
      ST_TICKB: begin
        val_q <= 16'(ticks);
      end
      ST_ENCODE: begin
        if (slot_free) begin
          out_addr_q <= addr_q;
          if (sat12 == 12'(spwm_pkg::DUTY_MAX)) begin
            out_on_q  <= 13'(spwm_pkg::TICKS);
            out_off_q <= '0;
          end else if (sat12 == 12'd0) begin
            out_on_q  <= '0;
            out_off_q <= 13'(spwm_pkg::TICKS);
          end else begin
            out_on_q  <= '0;
            out_off_q <= {1'b0, sat12};
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.reg_address = out_addr_q;
  assign res_o.on_count    = out_on_q;
  assign res_o.off_count   = out_off_q;

endmodule

FILE: src/spwm_limit_table.sv
// Per-channel pulse limit table: synchronous RAM with registered read data.
// Depends on spwm_pkg. Per-entry valid bits make unwritten entries read zero.
module spwm_limit_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spwm_pkg::tbl_req_t req_i,
  output spwm_pkg::limit_t   rdata_o
);

  spwm_pkg::limit_t                 mem [spwm_pkg::CHANNELS];
  spwm_pkg::limit_t                 rd_q;
  logic [spwm_pkg::CHANNELS-1:0]    vld_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= vld_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule

FILE: src/spwm_checker.sv
// Port-level checks of the servo/PWM command encoder, bound to the top level.
// Depends on spwm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cmd_valid_i,
  input logic        cmd_ready_i,
  input logic [1:0]  cmd_opcode_i,
  input logic [3:0]  cmd_channel_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [7:0]  res_addr_i,
  input logic [12:0] res_on_i,
  input logic [12:0] res_off_i
);

  logic stalled;
  logic servo_fire;
  logic word_ok;
  logic addr_ok;

  assign stalled    = res_valid_i && !res_ready_i;
  assign servo_fire = cmd_valid_i && cmd_ready_i &&
                      (cmd_opcode_i == spwm_pkg::OP_SERVO) &&
                      (int'(cmd_channel_i) < spwm_pkg::CHANNELS);
  assign word_ok    = (res_on_i == 13'(spwm_pkg::TICKS) && res_off_i == 13'd0) ||
                      (res_on_i == 13'd0 && res_off_i != 13'd0 &&
                       res_off_i != 13'(spwm_pkg::DUTY_MAX) &&
                       res_off_i <= 13'(spwm_pkg::TICKS));
  assign addr_ok    = (res_addr_i == 8'(spwm_pkg::ALL_LED_REG)) ||
                      (res_addr_i[1:0] == 2'b10);

  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, stalled, res_valid_i)
  `ASSERT_NEXT(a_res_stable, clk_i, rst_ni, stalled, $stable(res_addr_i) && $stable(res_on_i) && $stable(res_off_i))
  `ASSERT_IMPLIES(a_word_form, clk_i, rst_ni, res_valid_i, word_ok)
  `ASSERT_IMPLIES(a_addr_form, clk_i, rst_ni, res_valid_i, addr_ok)
  `ASSERT_NEXT(a_servo_busy, clk_i, rst_ni, servo_fire, !cmd_ready_i)

endmodule

bind servo_pwm_command_encoder_core spwm_checker u_spwm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cmd_valid_i   (cmd_i.valid),
  .cmd_ready_i   (cmd_i.ready),
  .cmd_opcode_i  (cmd_i.opcode),
  .cmd_channel_i (cmd_i.channel),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .res_addr_i    (res_o.reg_address),
  .res_on_i      (res_o.on_count),
  .res_off_i     (res_o.off_count)
);

FILE: sim/servo_pwm_command_encoder_core_tb.sv
// Self-checking testbench for the servo/PWM command encoder: drives commands, config writes
// and result back-pressure, and predicts every LED register word in its own model.
// Depends on spwm_pkg, the spwm_*_if interfaces and servo_pwm_command_encoder_core.
module servo_pwm_command_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spwm_pkg::*;

  // Opcode 3 has no meaning; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Extra wait after the last queued word, so the block is idle before config writes.
  localparam int DRAIN_CYCLES = 12;
  // Long receiver hold-off used to fill the block and stall its input.
  localparam int HOLD_CYCLES = 400;
  // Slowest legal gap between transfers is a servo command behind the hold-off,
  // plus random stalls on both sides; take that many times over.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [3:0]         channel;
    logic               all_channels;
    logic signed [15:0] servo_value;
    logic [31:0]        duty_value;
    logic [14:0]        pulse_min;
    logic [14:0]        pulse_max;
  } cmd_item_t;

  typedef struct packed {
    logic [7:0]  reg_address;
    logic [12:0] on_count;
    logic [12:0] off_count;
  } led_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  spwm_cmd_if cmd_if();
  spwm_res_if res_if();
  spwm_cfg_if cfg_if();

  servo_pwm_command_encoder_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the limit table and the resolution register.
  logic [14:0] min_us [CHANNELS];
  logic [14:0] max_us [CHANNELS];
  logic [5:0]  res_bits = 6'(WRES_RESET);

  led_word_t pending_words[$];
  int        fault_count = 0;

  bit   tx_gaps     = 1'b1;
  bit   rx_gaps     = 1'b1;
  bit   hold_active = 1'b0;
  event hold_off_go;

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      min_us[i] = '0;
      max_us[i] = '0;
    end
  end

  function automatic void note_fault(string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Cut to 16 bits, saturate at 4095, then apply the full-on / full-off encodings.
  function automatic led_word_t led_word(logic [7:0] addr, logic [31:0] val);
    led_word_t   w;
    logic [15:0] v;
    v = val[15:0];
    if (v > DUTY_MAX) v = 16'(DUTY_MAX);
    w.reg_address = addr;
    if (v == DUTY_MAX) begin
      w.on_count  = 13'(TICKS);
      w.off_count = '0;
    end else if (v == 0) begin
      w.on_count  = '0;
      w.off_count = 13'(TICKS);
    end else begin
      w.on_count  = '0;
      w.off_count = v[12:0];
    end
    return w;
  endfunction

  // Angle or pulse in, clamp to the channel limits, convert microseconds to frame ticks.
  function automatic led_word_t servo_word(logic [3:0] ch, logic signed [15:0] sv);
    int lo;
    int hi;
    int pulse;
    int ticks;
    lo    = int'(min_us[ch]);
    hi    = int'(max_us[ch]);
    pulse = int'(sv);
    if (pulse < ANGLE_LIMIT) begin
      if (pulse < 0) pulse = 0;
      else if (pulse > ANGLE_MAX) pulse = ANGLE_MAX;
      // SV integer division truncates toward zero, as a reversed range needs.
      pulse = pulse * (hi - lo) / ANGLE_MAX + lo;
    end
    // Min test first: with min above max, anything at or above min lands on max.
    if (pulse < lo) pulse = lo;
    else if (pulse > hi) pulse = hi;
    ticks = pulse * TICKS / FRAME_US;
    return led_word(8'(LED_BASE + 4 * int'(ch)), 32'(ticks));
  endfunction

  // Bring a duty value from the configured width to 12 bits.
  function automatic logic [31:0] duty_to_12bit(logic [31:0] value, logic [5:0] bits);
    int shift;
    if (bits == DUTY_BITS) return (value >= TICKS) ? 32'(DUTY_MAX) : value;
    if (bits > DUTY_BITS) begin
      shift = int'(bits) - DUTY_BITS;
      return (shift >= 32) ? 32'd0 : (value >> shift);
    end
    // Narrower source: shift up within 32 bits and let the top bits wrap off.
    return value << (DUTY_BITS - int'(bits));
  endfunction

  // Update the shadow table and queue the word this command should produce.
  function automatic void apply_command(cmd_item_t c);
    logic [7:0] addr;
    case (c.opcode)
      OP_ATTACH: begin
        min_us[c.channel] = c.pulse_min;
        max_us[c.channel] = c.pulse_max;
      end
      OP_SERVO: pending_words.push_back(servo_word(c.channel, c.servo_value));
      OP_DUTY: begin
        addr = c.all_channels ? 8'(ALL_LED_REG) : 8'(LED_BASE + 4 * int'(c.channel));
        pending_words.push_back(led_word(addr, duty_to_12bit(c.duty_value, res_bits)));
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver back-pressure and the checker
  // ---------------------------------------------------------------------------

  // Drop ready at random, hold it high during steady stretches, hold it low on request.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_active) res_if.ready <= 1'b0;
      else if (!rx_gaps) res_if.ready <= 1'b1;
      else res_if.ready <= ($urandom_range(99) >= 26);
    end
  end

  // Count out the long hold-off in its own process.
  initial begin
    forever begin
      @(hold_off_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      hold_active <= 1'b0;
    end
  end

  function automatic void check_field(string name, logic [12:0] got, logic [12:0] want);
    if (got !== want) note_fault($sformatf("%s expected %0d got %0d", name, want, got));
  endfunction

  // Compare every result transfer against the oldest queued word.
  always @(posedge clk_i) begin
    led_word_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_words.size() == 0) begin
        note_fault($sformatf("unexpected result addr=%0d on=%0d off=%0d",
                             res_if.reg_address, res_if.on_count, res_if.off_count));
      end else begin
        want = pending_words.pop_front();
        check_field("reg_address", 13'(res_if.reg_address), 13'(want.reg_address));
        check_field("on_count", res_if.on_count, want.on_count);
        check_field("off_count", res_if.off_count, want.off_count);
      end
    end
  end

  // End the run if no transfer happens on any channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  // Offer one command, idling first at random; leave valid high so back-to-back
  // commands need no dead cycle.
  task automatic send_command(input cmd_item_t c);
    if (tx_gaps) begin
      while ($urandom_range(99) < 26) begin
        cmd_if.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.opcode       <= c.opcode;
    cmd_if.channel      <= c.channel;
    cmd_if.all_channels <= c.all_channels;
    cmd_if.servo_value  <= c.servo_value;
    cmd_if.duty_value   <= c.duty_value;
    cmd_if.pulse_min    <= c.pulse_min;
    cmd_if.pulse_max    <= c.pulse_max;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_command(c);
  endtask

  // Drop valid, wait for every queued word, then cover attach-only tails as well.
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_resolution(input logic [5:0] bits);
    wait_drained();
    cfg_if.valid            <= 1'b1;
    cfg_if.write_resolution <= bits;
    do @(posedge clk_i); while (!cfg_if.ready);
    res_bits = bits;
    cfg_if.valid <= 1'b0;
  endtask

  function automatic cmd_item_t make_cmd(logic [1:0] op, int ch, bit all, int sv,
                                         logic [31:0] duty, int pmin, int pmax);
    cmd_item_t c;
    c.opcode       = op;
    c.channel      = 4'(ch);
    c.all_channels = all;
    c.servo_value  = 16'(sv);
    c.duty_value   = duty;
    c.pulse_min    = 15'(pmin);
    c.pulse_max    = 15'(pmax);
    return c;
  endfunction

  function automatic logic [31:0] duty_mask();
    return (res_bits >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << res_bits) - 1);
  endfunction

  // Mostly well-formed servo and duty traffic with realistic limits; some
  // reversed or zero limits, boundary values and unused opcodes mixed in.
  function automatic cmd_item_t random_command();
    cmd_item_t   c;
    int          pick;
    logic [31:0] mask;
    c.channel      = 4'($urandom_range(15));
    c.all_channels = ($urandom_range(3) == 0);
    c.servo_value  = 16'($urandom);
    c.duty_value   = $urandom;
    c.pulse_min    = 15'($urandom_range(20000));
    c.pulse_max    = 15'($urandom_range(20000));
    pick = $urandom_range(99);
    if (pick < 12) c.opcode = OP_ATTACH;
    else if (pick < 15) c.opcode = OP_UNUSED;
    else if (pick < 57) c.opcode = OP_SERVO;
    else c.opcode = OP_DUTY;

    pick = $urandom_range(99);
    case (c.opcode)
      OP_ATTACH: begin
        if (pick < 60) begin
          c.pulse_min = 15'($urandom_range(1200, 400));
          c.pulse_max = 15'($urandom_range(2600, 1500));
        end else if (pick < 75) begin
          c.pulse_min = 15'($urandom_range(2600, 1500));
          c.pulse_max = 15'($urandom_range(1200, 400));
        end else if (pick < 85) begin
          c.pulse_min = '0;
          c.pulse_max = '0;
        end
      end
      OP_SERVO: begin
        if (pick < 40) c.servo_value = 16'(int'($urandom_range(230)) - 25);
        else if (pick < 65) c.servo_value = 16'($urandom_range(3000, 300));
        else if (pick < 75) c.servo_value = 16'($urandom_range(563, 545));
      end
      OP_DUTY: begin
        mask = duty_mask();
        if (pick < 50) c.duty_value = $urandom & mask;
        else if (pick < 80) begin
          case ($urandom_range(3))
            0: c.duty_value = 32'd0;
            1: c.duty_value = mask;
            2: c.duty_value = mask - 32'd1;
            default: c.duty_value = 32'd1;
          endcase
        end else if (pick < 90) c.duty_value = 32'($urandom_range(5));
      end
      default: ;
    endcase
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Unattached channels read as zero limits, so any servo write gives full off.
  task automatic test_detached_channels();
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 90, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 15, 1'b1, 1500, '0, 0, 0));
    send_command(make_cmd(OP_DUTY, 5, 1'b0, 0, 32'd0, 0, 0));
    send_command(make_cmd(OP_DUTY, 5, 1'b0, 0, 32'd255, 0, 0));
  endtask

  task automatic test_directed_extremes();
    // Angle range and its boundaries on a normal channel.
    send_command(make_cmd(OP_ATTACH, 0, 1'b1, 0, '0, 1000, 2000));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, -32768, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 0, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 90, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 180, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 553, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 554, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 0, 1'b1, 32767, '0, 0, 0));
    // Reversed limits: negative slope in the angle map and min-first clamping.
    send_command(make_cmd(OP_ATTACH, 15, 1'b0, 0, '0, 2000, 1000));
    send_command(make_cmd(OP_SERVO, 15, 1'b0, 90, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 15, 1'b0, 1500, '0, 0, 0));
    send_command(make_cmd(OP_SERVO, 15, 1'b0, 32767, '0, 0, 0));
    // Full-frame pulse rounds to 4096 ticks and saturates to full on.
    send_command(make_cmd(OP_ATTACH, 7, 1'b0, 0, '0, 0, 20000));
    send_command(make_cmd(OP_SERVO, 7, 1'b0, 180, '0, 0, 0));
    send_command(make_cmd(OP_ATTACH, 3, 1'b0, 0, '0, 20000, 0));
    send_command(make_cmd(OP_SERVO, 3, 1'b0, 600, '0, 0, 0));
    // All-LED register, wrapped high bits, and the unused opcode.
    send_command(make_cmd(OP_DUTY, 15, 1'b1, 0, 32'd128, 0, 0));
    send_command(make_cmd(OP_DUTY, 9, 1'b0, 0, 32'hFFFF_FFFF, 0, 0));
    send_command(make_cmd(OP_UNUSED, 0, 1'b1, 90, 32'hFFFF_FFFF, 20000, 20000));
    send_command(make_cmd(OP_SERVO, 0, 1'b0, 180, '0, 0, 0));
  endtask

  task automatic test_random_mix(input int count);
    // Open with a stretch with no idling on either side.
    tx_gaps = 1'b0;
    rx_gaps <= 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i == 200) begin
        tx_gaps = 1'b1;
        rx_gaps <= 1'b1;
      end
      send_command(random_command());
    end
  endtask

  // Stall the receiver for a long stretch while commands keep coming.
  task automatic test_backpressure();
    cmd_item_t c;
    tx_gaps = 1'b0;
    -> hold_off_go;
    for (int i = 0; i < 60; i++) begin
      c = random_command();
      if (c.opcode != OP_SERVO) c.opcode = OP_DUTY;
      send_command(c);
    end
    tx_gaps = 1'b1;
  endtask

  // Walk the resolution register through its extremes and the 12-bit edges.
  task automatic test_resolution_sweep(input int per_setting);
    logic [5:0]  settings [10];
    logic [31:0] mask;
    settings = '{6'd1, 6'd32, 6'd12, 6'd16, 6'd31, 6'd13, 6'd11, 6'd2, 6'd8, 6'd0};
    settings[9] = 6'($urandom_range(32, 1));
    foreach (settings[s]) begin
      set_resolution(settings[s]);
      mask = duty_mask();
      send_command(make_cmd(OP_DUTY, 4, 1'b0, 0, 32'd0, 0, 0));
      send_command(make_cmd(OP_DUTY, 11, 1'b1, 0, mask, 0, 0));
      send_command(make_cmd(OP_DUTY, 0, 1'b0, 0, 32'd4095, 0, 0));
      send_command(make_cmd(OP_DUTY, 15, 1'b0, 0, 32'd4096, 0, 0));
      send_command(make_cmd(OP_DUTY, 6, 1'b1, 0, 32'd1, 0, 0));
      for (int i = 0; i < per_setting; i++) send_command(random_command());
    end
  endtask

  initial begin
    cmd_if.valid            <= 1'b0;
    cmd_if.opcode           <= OP_ATTACH;
    cmd_if.channel          <= '0;
    cmd_if.all_channels     <= 1'b0;
    cmd_if.servo_value      <= '0;
    cmd_if.duty_value       <= '0;
    cmd_if.pulse_min        <= '0;
    cmd_if.pulse_max        <= '0;
    cfg_if.valid            <= 1'b0;
    cfg_if.write_resolution <= 6'(WRES_RESET);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_detached_channels();
    test_directed_extremes();
    test_random_mix(550);
    test_backpressure();
    test_resolution_sweep(85);

    wait_drained();
    if (pending_words.size() != 0)
      note_fault($sformatf("%0d results never arrived", pending_words.size()));
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
